[design/pva_pkg.sv]
// ----------------------------------------------------------------------------
// pva_pkg
// Shared types and constants of the polyphonic voice allocator.
// ----------------------------------------------------------------------------
package pva_pkg;

    localparam int PVA_VOICES      = 4;
    localparam int PVA_REPORTED    = 4;
    localparam int PVA_QUEUE_DEPTH = 2;

    localparam int NOTE_W = 7;
    localparam int VEL_W  = 7;
    localparam int CV_W   = 16;
    localparam int OCT_W  = 4;
    localparam int SEMI_W = 5;
    localparam int CENT_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEMITONE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENT     = 2'd2;

    localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
    localparam logic [3:0] KIND_NOTE_OFF = 4'h8;

    localparam logic [CV_W-1:0] CENTS_PER_OCTAVE   = 16'd1200;
    localparam logic [CV_W-1:0] CENTS_PER_SEMITONE = 16'd100;

    typedef logic [1:0] t_op;
    localparam t_op OP_NONE  = 2'd0;
    localparam t_op OP_ON    = 2'd1;
    localparam t_op OP_OFF   = 2'd2;
    localparam t_op OP_PANIC = 2'd3;

    typedef struct packed {
        t_op               op;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  vel;
    } t_cmd;

    typedef struct packed {
        logic signed [OCT_W-1:0]  octave;
        logic signed [SEMI_W-1:0] semitone;
        logic signed [CENT_W-1:0] cent;
    } t_cfg;

endpackage

[design/pva_front.sv]
// ----------------------------------------------------------------------------
// pva_front
// Classifies an incoming request into a voice command.
// ----------------------------------------------------------------------------
module pva_front import pva_pkg::*; (
    input  logic              i_req_type,
    input  logic [7:0]        i_status_byte,
    input  logic [NOTE_W-1:0] i_note_number,
    input  logic [VEL_W-1:0]  i_note_velocity,
    output t_cmd              o_cmd
);

    always_comb begin
        o_cmd.note = i_note_number;
        o_cmd.vel  = i_note_velocity;
        if (i_req_type) begin
            o_cmd.op = OP_PANIC;
        end else if (i_status_byte[7:4] == KIND_NOTE_ON) begin
            o_cmd.op = OP_ON;
        end else if (i_status_byte[7:4] == KIND_NOTE_OFF) begin
            o_cmd.op = OP_OFF;
        end else begin
            o_cmd.op = OP_NONE;
        end
    end

endmodule

[design/pva_queue.sv]
// ----------------------------------------------------------------------------
// pva_queue
// Short command queue between the classifier and the voice engine.
// ----------------------------------------------------------------------------
module pva_queue import pva_pkg::*; #(
    parameter int DEPTH = PVA_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_ready,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          w_push, w_pop;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

[design/pva_back.sv]
// ----------------------------------------------------------------------------
// pva_back
// Voice engine: updates the voice table and registers the CV result.
// ----------------------------------------------------------------------------
module pva_back import pva_pkg::*; #(
    parameter int VOICES = PVA_VOICES
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_cmd_valid,
    input  t_cmd                   i_cmd,
    output logic                   o_cmd_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic signed [CV_W-1:0] o_cv [PVA_REPORTED],
    output logic [PVA_REPORTED-1:0] o_gate_bits,
    output logic [VEL_W-1:0]       o_velocity_level
);

    localparam int PW = (VOICES > 1) ? $clog2(VOICES) : 1;

    logic [NOTE_W-1:0] r_note [VOICES];
    logic [NOTE_W-1:0] n_note [VOICES];
    logic [VOICES-1:0] r_busy, n_busy;
    logic [VEL_W-1:0]  r_vel, n_vel;
    logic [PW-1:0]     r_ptr, n_ptr;
    logic signed [CV_W-1:0] r_base;
    logic signed [CV_W-1:0] n_cv [PVA_REPORTED];
    logic [PVA_REPORTED-1:0] n_gate;
    logic                    r_out_valid;
    logic signed [CV_W-1:0]  r_cv [PVA_REPORTED];
    logic [PVA_REPORTED-1:0] r_gate;
    logic [VEL_W-1:0]        r_out_vel;
    logic                    w_pop;
    logic                    found;

    assign w_pop     = i_cmd_valid && (!r_out_valid || i_out_ready);
    assign o_cmd_pop = w_pop;

    always_comb begin
        n_note = r_note;
        n_busy = r_busy;
        n_vel  = r_vel;
        n_ptr  = r_ptr;
        found  = 1'b0;
        unique case (i_cmd.op)
            OP_PANIC: begin
                for (int i = 0; i < VOICES; i++) begin
                    n_note[i] = '0;
                end
                n_busy = '0;
            end
            OP_ON: begin
                for (int i = 0; i < VOICES; i++) begin
                    if (!found && !r_busy[i]) begin
                        n_note[i] = i_cmd.note;
                        n_busy[i] = 1'b1;
                        found     = 1'b1;
                    end
                end
                if (!found) begin
                    for (int i = 0; i < VOICES; i++) begin
                        if (r_ptr == PW'(i)) begin
                            n_note[i] = i_cmd.note;
                        end
                    end
                    n_ptr = (r_ptr == PW'(VOICES - 1)) ? '0 : r_ptr + 1'b1;
                end
                n_vel = i_cmd.vel;
            end
            OP_OFF: begin
                for (int i = 0; i < VOICES; i++) begin
                    if (!found && r_busy[i] && (r_note[i] == i_cmd.note)) begin
                        n_note[i] = '0;
                        n_busy[i] = 1'b0;
                        found     = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        if (n_busy == '0) begin
            n_vel = '0;
            n_ptr = '0;
        end
    end

    for (genvar g = 0; g < PVA_REPORTED; g++) begin : g_rep
        if (g < VOICES) begin : g_live
            assign n_cv[g]   = r_base
                             + $signed(CV_W'({9'd0, n_note[g]}) * CENTS_PER_SEMITONE);
            assign n_gate[g] = n_busy[g];
        end else begin : g_dead
            assign n_cv[g]   = '0;
            assign n_gate[g] = 1'b0;
        end
    end

    // tune offset in cents, follows the config registers
    always_ff @(posedge i_clk) begin
        r_base <= $signed(CV_W'($signed(i_cfg.octave)) * CENTS_PER_OCTAVE)
                + $signed(CV_W'($signed(i_cfg.semitone)) * CENTS_PER_SEMITONE)
                + CV_W'($signed(i_cfg.cent));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < VOICES; i++) begin
                r_note[i] <= '0;
            end
            r_busy      <= '0;
            r_vel       <= '0;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_pop) begin
                r_note      <= n_note;
                r_busy      <= n_busy;
                r_vel       <= n_vel;
                r_ptr       <= n_ptr;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_cv      <= n_cv;
            r_gate    <= n_gate;
            r_out_vel <= n_vel;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_cv             = r_cv;
    assign o_gate_bits      = r_gate;
    assign o_velocity_level = r_out_vel;

endmodule

[design/poly_voice_allocator_cv.sv]
// ----------------------------------------------------------------------------
// poly_voice_allocator_cv
// Polyphonic MIDI voice allocator with round-robin steal and pitch CV out.
// ----------------------------------------------------------------------------
// channel  direction  handshake                 payload
// in       input      i_in_valid / o_in_ready   req_type, status, note, velocity
// out      output     o_out_valid / i_out_ready pitch_cv_0..3, gate_bits, velocity
// cfg      input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One transfer per cycle sustained while neither channel stalls; each result passes
// through the 2-entry command queue and then the output register.
// Synchronous active-low reset empties the queue and clears the voice table.
// Output stalls back up into the queue; input stalls only when the queue is full.
// Config writes always complete: o_cfg_ready is tied high.
// ----------------------------------------------------------------------------
module poly_voice_allocator_cv import pva_pkg::*; #(
    parameter int VOICES = PVA_VOICES
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_req_type,
    input  logic [7:0]             i_status_byte,
    input  logic [NOTE_W-1:0]      i_note_number,
    input  logic [VEL_W-1:0]       i_note_velocity,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic signed [CV_W-1:0] o_pitch_cv_0,
    output logic signed [CV_W-1:0] o_pitch_cv_1,
    output logic signed [CV_W-1:0] o_pitch_cv_2,
    output logic signed [CV_W-1:0] o_pitch_cv_3,
    output logic [3:0]             o_gate_bits,
    output logic [VEL_W-1:0]       o_velocity_level,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg r_cfg;
    t_cmd w_cmd_in;
    t_cmd w_cmd_head;
    logic w_head_valid;
    logic w_pop;
    logic signed [CV_W-1:0] w_cv [PVA_REPORTED];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_OCTAVE:   r_cfg.octave   <= i_cfg_data[OCT_W-1:0];
                CFG_SEMITONE: r_cfg.semitone <= i_cfg_data[SEMI_W-1:0];
                CFG_CENT:     r_cfg.cent     <= i_cfg_data[CENT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    pva_front u_front (
        .i_req_type      (i_req_type),
        .i_status_byte   (i_status_byte),
        .i_note_number   (i_note_number),
        .i_note_velocity (i_note_velocity),
        .o_cmd           (w_cmd_in)
    );

    pva_queue #(
        .DEPTH (PVA_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_cmd   (w_cmd_in),
        .o_ready (o_in_ready),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_cmd   (w_cmd_head)
    );

    pva_back #(
        .VOICES (VOICES)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_cmd_valid      (w_head_valid),
        .i_cmd            (w_cmd_head),
        .o_cmd_pop        (w_pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_cv             (w_cv),
        .o_gate_bits      (o_gate_bits),
        .o_velocity_level (o_velocity_level)
    );

    assign o_pitch_cv_0 = w_cv[0];
    assign o_pitch_cv_1 = w_cv[1];
    assign o_pitch_cv_2 = w_cv[2];
    assign o_pitch_cv_3 = w_cv[3];

endmodule

[design/pva_checker.sv]
// ----------------------------------------------------------------------------
// pva_checker
// Port-level checks of the voice allocator, bound to the top level.
// ----------------------------------------------------------------------------
module pva_checker import pva_pkg::*; #(
    parameter int VOICES = PVA_VOICES
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_in_ready,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input logic signed [CV_W-1:0] o_pitch_cv_0,
    input logic signed [CV_W-1:0] o_pitch_cv_1,
    input logic [3:0]             o_gate_bits,
    input logic [VEL_W-1:0]       o_velocity_level
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("result or full queue right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pitch_cv_0)
            && $stable(o_gate_bits) && $stable(o_velocity_level))
        else $error("stalled result changed");

    a_idle_velocity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (VOICES <= 4) && (o_gate_bits == 4'd0)
            |-> o_velocity_level == '0)
        else $error("velocity kept with all voices free");

    a_idle_cv_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_gate_bits[0] && !o_gate_bits[1]
            |-> o_pitch_cv_0 == o_pitch_cv_1)
        else $error("free voices report different pitch");

    a_gate_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (VOICES < 4) |-> o_gate_bits[3] == 1'b0)
        else $error("gate set on a missing voice");

endmodule

bind poly_voice_allocator_cv pva_checker #(
    .VOICES (VOICES)
) u_pva_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_pitch_cv_0     (o_pitch_cv_0),
    .o_pitch_cv_1     (o_pitch_cv_1),
    .o_gate_bits      (o_gate_bits),
    .o_velocity_level (o_velocity_level)
);

[tb/sv/tb_poly_voice_allocator_cv.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_poly_voice_allocator_cv
// Self-checking bench for the four-voice allocator. Streams note-on, note-off,
// panic and stray MIDI traffic under several tuning settings with random
// stalls on both channels. Each accepted request is played against a local
// voice table, and every returned voice frame is checked field by field.
// ----------------------------------------------------------------------------
module tb_poly_voice_allocator_cv;
    import pva_pkg::*;

    localparam logic REQ_MIDI  = 1'b0;
    localparam logic REQ_PANIC = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 240;
    localparam int BURST_ITEMS = 80;
    localparam int RECENT_MAX  = 6;

    typedef struct packed {
        logic              req_type;
        logic [7:0]        status;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  vel;
    } t_midi_req;

    typedef struct packed {
        logic [PVA_REPORTED-1:0][CV_W-1:0] cv;
        logic [3:0]                        gates;
        logic [VEL_W-1:0]                  vel;
    } t_voice_frame;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic                   i_req_type = 1'b0;
    logic [7:0]             i_status_byte = '0;
    logic [NOTE_W-1:0]      i_note_number = '0;
    logic [VEL_W-1:0]       i_note_velocity = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic signed [CV_W-1:0] o_pitch_cv_0;
    logic signed [CV_W-1:0] o_pitch_cv_1;
    logic signed [CV_W-1:0] o_pitch_cv_2;
    logic signed [CV_W-1:0] o_pitch_cv_3;
    logic [3:0]             o_gate_bits;
    logic [VEL_W-1:0]       o_velocity_level;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    // voice table and tuning as the block should hold them
    logic [NOTE_W-1:0] voice_note [PVA_VOICES];
    logic              voice_busy [PVA_VOICES];
    logic [VEL_W-1:0]  last_vel;
    int                steal_ptr;
    t_cfg              tuning;

    t_midi_req         midi_q[$];
    t_voice_frame      pending_frames[$];
    logic [NOTE_W-1:0] recent_notes[$];

    logic        in_fire = 1'b0;
    logic        cfg_fire = 1'b0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_ticket = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;

    int mismatch_count = 0;
    int request_count = 0;
    int result_count = 0;
    int note_on_count = 0;
    int steal_count = 0;
    int panic_count = 0;
    int cfg_write_count = 0;

    poly_voice_allocator_cv dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_req_type       (i_req_type),
        .i_status_byte    (i_status_byte),
        .i_note_number    (i_note_number),
        .i_note_velocity  (i_note_velocity),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_pitch_cv_0     (o_pitch_cv_0),
        .o_pitch_cv_1     (o_pitch_cv_1),
        .o_pitch_cv_2     (o_pitch_cv_2),
        .o_pitch_cv_3     (o_pitch_cv_3),
        .o_gate_bits      (o_gate_bits),
        .o_velocity_level (o_velocity_level),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic void clear_voices();
        for (int v = 0; v < PVA_VOICES; v++) begin
            voice_note[v] = '0;
            voice_busy[v] = 1'b0;
        end
        last_vel = '0;
        steal_ptr = 0;
    endfunction

    function automatic t_voice_frame play_request(input t_midi_req req);
        t_voice_frame frame;
        logic done;
        logic any_busy;
        int base;
        done = 1'b0;
        any_busy = 1'b0;
        if (req.req_type == REQ_PANIC) begin
            clear_voices();
            panic_count++;
        end else if (req.status[7:4] == KIND_NOTE_ON) begin
            note_on_count++;
            for (int v = 0; v < PVA_VOICES; v++) begin
                if (!done && !voice_busy[v]) begin
                    voice_note[v] = req.note;
                    voice_busy[v] = 1'b1;
                    done = 1'b1;
                end
            end
            if (!done) begin
                voice_note[steal_ptr] = req.note;
                voice_busy[steal_ptr] = 1'b1;
                steal_ptr = (steal_ptr + 1) % PVA_VOICES;
                steal_count++;
            end
            last_vel = req.vel;
        end else if (req.status[7:4] == KIND_NOTE_OFF) begin
            // only active voices may match, so idle slots holding 0 never do
            for (int v = 0; v < PVA_VOICES; v++) begin
                if (!done && voice_busy[v] && voice_note[v] == req.note) begin
                    voice_note[v] = '0;
                    voice_busy[v] = 1'b0;
                    done = 1'b1;
                end
            end
        end
        for (int v = 0; v < PVA_VOICES; v++)
            any_busy |= voice_busy[v];
        if (!any_busy) begin
            last_vel = '0;
            steal_ptr = 0;
        end
        base = int'($signed(tuning.octave)) * int'(CENTS_PER_OCTAVE)
             + int'($signed(tuning.semitone)) * int'(CENTS_PER_SEMITONE)
             + int'($signed(tuning.cent));
        frame = '0;
        for (int v = 0; v < PVA_REPORTED; v++) begin
            if (v < PVA_VOICES) begin
                frame.cv[v] = CV_W'(base + int'(voice_note[v]) * int'(CENTS_PER_SEMITONE));
                frame.gates[v] = voice_busy[v];
            end
        end
        frame.vel = last_vel;
        return frame;
    endfunction

    function automatic t_midi_req make_request();
        t_midi_req req;
        int unsigned pick;
        int unsigned slot;
        logic [3:0] kind;
        pick = $urandom_range(99);
        req.req_type = REQ_MIDI;
        req.status = 8'($urandom);
        req.note = 7'($urandom);
        req.vel = 7'($urandom);
        if (pick < 4) begin
            req.req_type = REQ_PANIC;
            recent_notes.delete();
        end else if (pick < 48) begin
            req.status[7:4] = KIND_NOTE_ON;
            if (recent_notes.size() != 0 && $urandom_range(3) == 0)
                req.note = recent_notes[$urandom_range(recent_notes.size() - 1)];
            recent_notes.push_back(req.note);
            if (recent_notes.size() > RECENT_MAX)
                void'(recent_notes.pop_front());
        end else if (pick < 88) begin
            req.status[7:4] = KIND_NOTE_OFF;
            if (recent_notes.size() != 0 && $urandom_range(4) != 0) begin
                slot = $urandom_range(recent_notes.size() - 1);
                req.note = recent_notes[slot];
                recent_notes.delete(slot);
            end
        end else begin
            // any message kind the allocator ignores
            kind = 4'($urandom_range(13));
            req.status[7:4] = (kind >= KIND_NOTE_OFF) ? kind + 4'd2 : kind;
        end
        return req;
    endfunction

    function automatic void push_req(input logic req_type, input logic [7:0] status,
                                     input logic [NOTE_W-1:0] note,
                                     input logic [VEL_W-1:0] vel);
        midi_q.push_back('{req_type, status, note, vel});
    endfunction

    task automatic check_field(input string what, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(negedge i_clk);
        while (!cfg_fire);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic program_tuning(input int oct, input int semi, input int cent);
        write_reg(CFG_OCTAVE, CFG_DATA_W'(oct));
        write_reg(CFG_SEMITONE, CFG_DATA_W'(semi));
        write_reg(CFG_CENT, CFG_DATA_W'(cent));
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (midi_q.size() != 0 || i_in_valid || pending_frames.size() != 0);
    endtask

    // request driver
    always @(negedge i_clk) begin : drive_proc
        t_midi_req next_req;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire) begin
            if (midi_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_req = midi_q.pop_front();
                i_in_valid <= 1'b1;
                i_req_type <= next_req.req_type;
                i_status_byte <= next_req.status;
                i_note_number <= next_req.note;
                i_note_velocity <= next_req.vel;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // long output hold-off
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_ticket != hold_served) begin
            hold_served <= hold_ticket;
            hold_left <= HOLD_CYCLES;
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end

    // transfer sampling, prediction and frame check
    always @(posedge i_clk) begin : sample_proc
        t_midi_req    taken;
        t_voice_frame want;
        t_voice_frame got;
        in_fire <= i_in_valid && o_in_ready;
        cfg_fire <= i_cfg_valid && o_cfg_ready;
        if (!i_rst_n) begin
            clear_voices();
            tuning = '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                cfg_write_count++;
                case (i_cfg_index)
                    CFG_OCTAVE: begin
                        tuning.octave = i_cfg_data[OCT_W-1:0];
                    end
                    CFG_SEMITONE: begin
                        tuning.semitone = i_cfg_data[SEMI_W-1:0];
                    end
                    CFG_CENT: begin
                        tuning.cent = i_cfg_data[CENT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                taken = {i_req_type, i_status_byte, i_note_number, i_note_velocity};
                pending_frames.push_back(play_request(taken));
                request_count++;
            end
            if (o_out_valid && i_out_ready) begin
                result_count++;
                got = {o_pitch_cv_3, o_pitch_cv_2, o_pitch_cv_1, o_pitch_cv_0,
                       o_gate_bits, o_velocity_level};
                if (pending_frames.size() == 0) begin
                    $display("%0t ns: voice frame with no request outstanding", $time);
                    mismatch_count++;
                end else begin
                    want = pending_frames.pop_front();
                    for (int v = 0; v < PVA_REPORTED; v++)
                        check_field($sformatf("pitch_cv_%0d", v), $signed(want.cv[v]),
                                    $signed(got.cv[v]));
                    check_field("gate_bits", want.gates, got.gates);
                    check_field("velocity_level", want.vel, got.vel);
                end
            end
        end
    end

    initial begin : stimulus_proc
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 10;
        recv_idle_pct = 75;

        // directed: note 0 off on an idle table, fill, steals, misses, panics
        push_req(REQ_MIDI, {KIND_NOTE_OFF, 4'h0}, 7'd0, 7'd0);
        push_req(REQ_MIDI, {KIND_NOTE_ON, 4'h0}, 7'd0, 7'd0);
        push_req(REQ_MIDI, {KIND_NOTE_ON, 4'hF}, 7'd127, 7'd127);
        push_req(REQ_MIDI, {KIND_NOTE_ON, 4'h5}, 7'd60, 7'd64);
        push_req(REQ_MIDI, {KIND_NOTE_ON, 4'h0}, 7'd60, 7'd1);
        push_req(REQ_MIDI, {KIND_NOTE_ON, 4'h3}, 7'd72, 7'd100);
        push_req(REQ_MIDI, {KIND_NOTE_ON, 4'hC}, 7'd1, 7'd2);
        push_req(REQ_MIDI, {KIND_NOTE_OFF, 4'hA}, 7'd60, 7'd33);
        push_req(REQ_MIDI, {KIND_NOTE_OFF, 4'h0}, 7'd99, 7'd0);
        push_req(REQ_MIDI, 8'hA0, 7'd5, 7'd5);
        push_req(REQ_MIDI, 8'hF0, 7'd127, 7'd127);
        push_req(REQ_MIDI, 8'h00, 7'd0, 7'd0);
        push_req(REQ_MIDI, 8'hFF, 7'd64, 7'd64);
        push_req(REQ_MIDI, 8'h7F, 7'd60, 7'd60);
        push_req(REQ_PANIC, {KIND_NOTE_ON, 4'h0}, 7'd127, 7'd127);
        push_req(REQ_MIDI, {KIND_NOTE_OFF, 4'h0}, 7'd0, 7'd0);
        push_req(REQ_MIDI, {KIND_NOTE_ON, 4'h1}, 7'd5, 7'd9);
        push_req(REQ_MIDI, {KIND_NOTE_OFF, 4'h1}, 7'd5, 7'd9);
        push_req(REQ_MIDI, {KIND_NOTE_ON, 4'h2}, 7'd42, 7'd77);
        push_req(REQ_PANIC, 8'h00, 7'd0, 7'd0);
        drain();

        for (int phase = 1; phase <= 6; phase++) begin
            case (phase)
                1: program_tuning(4, 12, 100);
                2: program_tuning(-4, -12, -100);
                3: program_tuning(7, 15, 127);
                4: program_tuning(-8, -16, -128);
                5: program_tuning(int'($urandom_range(8)) - 4, int'($urandom_range(24)) - 12,
                                  int'($urandom_range(200)) - 100);
                default: begin
                    write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
                    program_tuning(int'($urandom), int'($urandom), int'($urandom));
                end
            endcase
            @(posedge i_clk);
            send_idle_pct = (phase <= 2) ? 10 : (phase <= 4) ? 75 : 0;
            recv_idle_pct = (phase <= 2) ? 75 : (phase <= 4) ? 10 : 0;
            if (phase == 5) begin
                // back-pressure burst: output held off while requests keep coming
                repeat (BURST_ITEMS) midi_q.push_back(make_request());
                hold_ticket++;
            end
            repeat (PHASE_ITEMS) midi_q.push_back(make_request());
            drain();
        end

        repeat (8) @(negedge i_clk);
        $display("Covered %0d requests: %0d note-on, %0d voice steals, %0d panics, %0d reg writes",
                 request_count, note_on_count, steal_count, panic_count, cfg_write_count);
        $display("Checked %0d voice frames, %0d mismatches", result_count, mismatch_count);
        if (mismatch_count == 0 && pending_frames.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Timed out with %0d requests queued and %0d frames outstanding",
                 midi_q.size(), pending_frames.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
